### rtl/core/hva_pkg.sv
// Shared types, constants and helper functions of the homogeneous vector ALU.
`timescale 1ns / 1ps
package hva_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int LANES     = 4;
	localparam int OP_W      = 4;
	localparam int EPS_W     = 16;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int WIDE_W    = PROD_W + 2;
	localparam int NUM_W     = WORD_W + FRAC_BITS;
	localparam int SQ_W      = PROD_W;
	localparam int ROOT_W    = SQ_W / 2;
	localparam int REM_W     = ROOT_W + 4;

	localparam int IN_W      = ((OP_W + 9 * WORD_W + 7) / 8) * 8;
	localparam int OUT_W     = ((5 * WORD_W + 4 + 7) / 8) * 8;
	localparam int A_LSB     = OP_W;
	localparam int B_LSB     = OP_W + LANES * WORD_W;
	localparam int S_LSB     = OP_W + 2 * LANES * WORD_W;
	localparam int SC_LSB    = LANES * WORD_W;
	localparam int EQ_BIT    = 5 * WORD_W;
	localparam int APT_BIT   = EQ_BIT + 1;
	localparam int AVEC_BIT  = EQ_BIT + 2;
	localparam int INV_BIT   = EQ_BIT + 3;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

	localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
	localparam logic [OP_W-1:0] OP_NEG   = 4'd2;
	localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
	localparam logic [OP_W-1:0] OP_DOT   = 4'd5;
	localparam logic [OP_W-1:0] OP_CROSS = 4'd6;
	localparam logic [OP_W-1:0] OP_MAG   = 4'd7;
	localparam logic [OP_W-1:0] OP_NORM  = 4'd8;
	localparam logic [OP_W-1:0] OP_CMP   = 4'd9;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t ONE      = word_t'(1) <<< FRAC_BITS;
	localparam logic signed [WIDE_W-1:0] HALF_LSB = WIDE_W'(1) <<< (FRAC_BITS - 1);

	typedef struct packed {
		word_t              res;
		logic               eq;
		logic               nsign;
		logic [NUM_W-1:0]   nmag;
	} lane_out_t;

	typedef struct packed {
		logic [OP_W-1:0]              op;
		word_t                        s;
		logic                         apt;
		logic                         avec;
		logic                         inv;
		logic                         eq;
		word_t                        scalar;
		logic [LANES-1:0][WORD_W-1:0] res;
		logic [LANES-1:0]             neg;
		logic [LANES-1:0][NUM_W-1:0]  nmag;
	} side_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		word_t           s;
		logic            apt;
		logic            avec;
		logic            inv;
	} base_t;

	function automatic word_t sat_word(input logic signed [WIDE_W-1:0] v);
		if (v > WIDE_W'(WORD_MAX))
			return WORD_MAX;
		if (v < WIDE_W'(WORD_MIN))
			return WORD_MIN;
		return v[WORD_W-1:0];
	endfunction

	function automatic logic close_to(input word_t x, input word_t y,
			input logic [EPS_W-1:0] eps);
		logic signed [WORD_W:0] d;
		logic [WORD_W:0] mag;
		d   = (WORD_W+1)'(x) - (WORD_W+1)'(y);
		mag = d[WORD_W] ? (WORD_W+1)'(-d) : d;
		return mag < (WORD_W+1)'(eps);
	endfunction

endpackage

### rtl/core/hva_lane.sv
// One component lane: products, add/sub/negate, rounding, match check and dividend preparation.
`timescale 1ns / 1ps
module hva_lane (
	input  logic                      clk,
	input  logic                      en,
	input  logic [hva_pkg::OP_W-1:0]  op,
	input  hva_pkg::word_t            a,
	input  hva_pkg::word_t            b,
	input  hva_pkg::word_t            s,
	input  hva_pkg::word_t            aj,
	input  hva_pkg::word_t            bk,
	input  hva_pkg::word_t            ak,
	input  hva_pkg::word_t            bj,
	input  logic [hva_pkg::EPS_W-1:0] eps,
	output logic signed [hva_pkg::PROD_W-1:0] prod_s2,
	output hva_pkg::lane_out_t        out_s3
);

	hva_pkg::word_t m0a, m0b, m1a, m1b, simple;
	logic signed [hva_pkg::PROD_W-1:0] p1_s2;
	hva_pkg::word_t simple_s2, a_s2;
	logic eq_s2;
	logic [hva_pkg::OP_W-1:0] op_s2;
	logic signed [hva_pkg::WIDE_W-1:0] wide, rnd;
	logic signed [hva_pkg::NUM_W-1:0] num;

	always_comb begin
		m0a = '0;
		m0b = '0;
		m1a = '0;
		m1b = '0;
		simple = '0;
		case (op) inside
			hva_pkg::OP_SCALE: begin
				m0a = a;
				m0b = s;
			end
			hva_pkg::OP_DOT: begin
				m0a = a;
				m0b = b;
			end
			hva_pkg::OP_MAG, hva_pkg::OP_NORM: begin
				m0a = a;
				m0b = a;
			end
			hva_pkg::OP_CROSS: begin
				m0a = aj;
				m0b = bk;
				m1a = ak;
				m1b = bj;
			end
			hva_pkg::OP_ADD: simple = hva_pkg::sat_word(hva_pkg::WIDE_W'(a) + hva_pkg::WIDE_W'(b));
			hva_pkg::OP_SUB: simple = hva_pkg::sat_word(hva_pkg::WIDE_W'(a) - hva_pkg::WIDE_W'(b));
			hva_pkg::OP_NEG: simple = hva_pkg::sat_word(-hva_pkg::WIDE_W'(a));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2   <= hva_pkg::PROD_W'(m0a) * hva_pkg::PROD_W'(m0b);
			p1_s2     <= hva_pkg::PROD_W'(m1a) * hva_pkg::PROD_W'(m1b);
			simple_s2 <= simple;
			eq_s2     <= hva_pkg::close_to(a, b, eps);
			a_s2      <= a;
			op_s2     <= op;
		end
	end

	// round to nearest step, ties upward
	always_comb begin
		wide = hva_pkg::WIDE_W'(prod_s2) - hva_pkg::WIDE_W'(p1_s2) + hva_pkg::HALF_LSB;
		rnd  = wide >>> hva_pkg::FRAC_BITS;
		num  = {a_s2, hva_pkg::FRAC_BITS'(0)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (op_s2) inside
				hva_pkg::OP_ADD, hva_pkg::OP_SUB, hva_pkg::OP_NEG: out_s3.res <= simple_s2;
				hva_pkg::OP_SCALE, hva_pkg::OP_CROSS: out_s3.res <= hva_pkg::sat_word(rnd);
				default: out_s3.res <= '0;
			endcase
			out_s3.eq    <= eq_s2;
			out_s3.nsign <= a_s2[hva_pkg::WORD_W-1];
			out_s3.nmag  <= a_s2[hva_pkg::WORD_W-1] ? hva_pkg::NUM_W'(-num) : num;
		end
	end

endmodule

### rtl/core/hva_merge.sv
// Merge stage: dot-product sum with rounding and saturating sum of squares.
`timescale 1ns / 1ps
module hva_merge (
	input  logic                     clk,
	input  logic                     en,
	input  logic [hva_pkg::OP_W-1:0] op,
	input  logic signed [hva_pkg::PROD_W-1:0] prod [hva_pkg::LANES],
	output hva_pkg::word_t           dot_s3,
	output logic [hva_pkg::SQ_W-1:0] sq_s3
);

	logic signed [hva_pkg::WIDE_W-1:0] dsum, drnd;
	logic [hva_pkg::SQ_W+1:0] qsum;

	always_comb begin
		dsum = hva_pkg::HALF_LSB;
		qsum = '0;
		for (int i = 0; i < hva_pkg::LANES; i++) begin
			dsum = dsum + hva_pkg::WIDE_W'(prod[i]);
			qsum = qsum + (hva_pkg::SQ_W+2)'(unsigned'(prod[i]));
		end
		drnd = dsum >>> hva_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= (op == hva_pkg::OP_DOT) ? hva_pkg::sat_word(drnd) : '0;
			// clamp the square sum at all ones
			sq_s3  <= (qsum[hva_pkg::SQ_W+1:hva_pkg::SQ_W] != '0) ? '1 : qsum[hva_pkg::SQ_W-1:0];
		end
	end

endmodule

### rtl/core/hva_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module hva_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hva_pkg::SQ_W-1:0]   x,
	output logic [hva_pkg::ROOT_W-1:0] root
);

	localparam int N = hva_pkg::ROOT_W;
	localparam int R = hva_pkg::REM_W;
	localparam int X = hva_pkg::SQ_W;

	logic [R-1:0] rem_q  [N];
	logic [N-1:0] root_q [N];
	logic [X-1:0] x_q    [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [R-1:0] rin, r2, tr;
		logic [N-1:0] qin;
		logic [X-1:0] xin;
		if (k == 0) begin : g_first
			assign rin = '0;
			assign qin = '0;
			assign xin = x;
		end else begin : g_next
			assign rin = rem_q[k-1];
			assign qin = root_q[k-1];
			assign xin = x_q[k-1];
		end
		assign r2 = {rin[R-3:0], xin[X-1:X-2]};
		assign tr = R'({qin, 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= tr) begin
					rem_q[k]  <= r2 - tr;
					root_q[k] <= {qin[N-2:0], 1'b1};
				end else begin
					rem_q[k]  <= r2;
					root_q[k] <= {qin[N-2:0], 1'b0};
				end
				x_q[k] <= {xin[X-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[N-1];

endmodule

### rtl/core/hva_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module hva_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hva_pkg::NUM_W-1:0]  num,
	input  logic [hva_pkg::WORD_W-1:0] den,
	output logic [hva_pkg::NUM_W-1:0]  quo
);

	localparam int N = hva_pkg::NUM_W;
	localparam int D = hva_pkg::WORD_W;

	logic [D-1:0] rem_q [N];
	logic [N-1:0] quo_q [N];
	logic [N-1:0] num_q [N];
	logic [D-1:0] den_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D-1:0] rin, din;
		logic [N-1:0] qin, nin;
		logic [D:0] r2;
		logic ge;
		if (k == 0) begin : g_first
			assign rin = '0;
			assign qin = '0;
			assign nin = num;
			assign din = den;
		end else begin : g_next
			assign rin = rem_q[k-1];
			assign qin = quo_q[k-1];
			assign nin = num_q[k-1];
			assign din = den_q[k-1];
		end
		assign r2 = {rin, nin[N-1]};
		assign ge = r2 >= {1'b0, din};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? D'(r2 - {1'b0, din}) : r2[D-1:0];
				quo_q[k] <= {qin[N-2:0], ge};
				num_q[k] <= {nin[N-2:0], 1'b0};
				den_q[k] <= din;
			end
		end
	end

	assign quo = quo_q[N-1];

endmodule

### rtl/core/homogeneous_vector_alu.sv
// Top level of the homogeneous vector ALU: input decode, lanes, root, dividers, output register.
// Usage:
//   s_* carries one operation per transaction: an op code, tuples a and b and a scalar.
//   m_* returns one result transaction per input: four tuple components, a scalar
//   and the equal / point / vector / invalid flags.
//   epsilon_we with epsilon_wdata loads the match tolerance; write it only while idle.
// Pipeline: every operation passes the input, product and rounding registers, 32 stages
//   of square root, then 48 stages of divider (one quotient bit per stage), then the
//   output register.
// Throughput: one transaction per cycle while s_tready is high; every unit is fully pipelined.
// Reset: valid bits clear, epsilon returns to 7; no results are pending afterwards.
// Stall: while a result waits unread in the output register the pipeline keeps moving
//   as long as its final stage is empty; once a finished result sits behind the held
//   one, all stages freeze and s_tready drops until m_tready is seen.
`timescale 1ns / 1ps
module homogeneous_vector_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// op[3:0], ax, ay, az, aw, bx, by, bz, bw, scale (32 each), zero pad
	input  logic [hva_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// rx, ry, rz, rw, scalar_out (32 each), equal, a_is_point, a_is_vector, invalid, zero pad
	output logic [hva_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       epsilon_we,
	input  logic [hva_pkg::EPS_W-1:0]  epsilon_wdata
);

	localparam int L  = hva_pkg::LANES;
	localparam int W  = hva_pkg::WORD_W;
	localparam int DA = hva_pkg::ROOT_W;
	localparam int DB = hva_pkg::NUM_W;

	logic [hva_pkg::EPS_W-1:0] eps_q;
	logic out_load, en;

	hva_pkg::word_t a_in [L];
	hva_pkg::word_t b_in [L];
	hva_pkg::word_t s_in;
	logic [hva_pkg::OP_W-1:0] op_in;
	logic apt_in, avec_in, bvec_in;
	hva_pkg::base_t base_in, base_s1, base_s2, base_s3;
	hva_pkg::word_t a_s1 [L];
	hva_pkg::word_t b_s1 [L];
	logic v_s1, v_s2, v_s3;

	logic signed [hva_pkg::PROD_W-1:0] prod_s2 [L];
	hva_pkg::lane_out_t lane_s3 [L];
	hva_pkg::word_t dot_s3;
	logic [hva_pkg::SQ_W-1:0] sq_s3;
	logic [hva_pkg::ROOT_W-1:0] root;
	logic [L-1:0] eq_lanes;

	hva_pkg::side_t side_in, mid, line_a_q [DA], line_b_q [DB];
	logic [DA-1:0] va_q;
	logic [DB-1:0] vb_q;
	logic [W-1:0] s_abs, den;
	logic [hva_pkg::NUM_W-1:0] quo [L];
	hva_pkg::side_t fin;
	logic [hva_pkg::OUT_W-1:0] out_d;

	assign out_load = !m_tvalid || m_tready;
	assign en       = out_load || !vb_q[DB-1];
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= hva_pkg::EPS_RESET;
		end else if (epsilon_we) begin
			eps_q <= epsilon_wdata;
		end
	end

	// input decode and flag evaluation
	always_comb begin
		op_in = s_tdata[hva_pkg::OP_W-1:0];
		s_in  = s_tdata[hva_pkg::S_LSB +: W];
		for (int i = 0; i < L; i++) begin
			a_in[i] = s_tdata[hva_pkg::A_LSB + i*W +: W];
			b_in[i] = s_tdata[hva_pkg::B_LSB + i*W +: W];
		end
		apt_in  = hva_pkg::close_to(a_in[L-1], hva_pkg::ONE, eps_q);
		avec_in = hva_pkg::close_to(a_in[L-1], '0, eps_q);
		bvec_in = hva_pkg::close_to(b_in[L-1], '0, eps_q);
		base_in.op   = op_in;
		base_in.s    = s_in;
		base_in.apt  = apt_in;
		base_in.avec = avec_in;
		case (op_in) inside
			hva_pkg::OP_ADD: base_in.inv = !(avec_in || bvec_in);
			hva_pkg::OP_SUB: base_in.inv = avec_in && !bvec_in;
			hva_pkg::OP_NEG, hva_pkg::OP_SCALE, hva_pkg::OP_DIV, hva_pkg::OP_DOT,
			hva_pkg::OP_CROSS, hva_pkg::OP_MAG, hva_pkg::OP_NORM, hva_pkg::OP_CMP:
				base_in.inv = 1'b0;
			default: base_in.inv = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= base_in;
			a_s1    <= a_in;
			b_s1    <= b_in;
			base_s2 <= base_s1;
			base_s3 <= base_s2;
		end
	end

	for (genvar i = 0; i < L; i++) begin : g_lane
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		hva_lane u_lane (
			.clk     (clk),
			.en      (en),
			.op      (base_s1.op),
			.a       (a_s1[i]),
			.b       (b_s1[i]),
			.s       (base_s1.s),
			.aj      ((i < 3) ? a_s1[J] : '0),
			.bk      ((i < 3) ? b_s1[K] : '0),
			.ak      ((i < 3) ? a_s1[K] : '0),
			.bj      ((i < 3) ? b_s1[J] : '0),
			.eps     (eps_q),
			.prod_s2 (prod_s2[i]),
			.out_s3  (lane_s3[i])
		);
		assign eq_lanes[i] = lane_s3[i].eq;
	end

	hva_merge u_merge (
		.clk    (clk),
		.en     (en),
		.op     (base_s2.op),
		.prod   (prod_s2),
		.dot_s3 (dot_s3),
		.sq_s3  (sq_s3)
	);

	hva_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    (sq_s3),
		.root (root)
	);

	always_comb begin
		side_in.op     = base_s3.op;
		side_in.s      = base_s3.s;
		side_in.apt    = base_s3.apt;
		side_in.avec   = base_s3.avec;
		side_in.inv    = base_s3.inv;
		side_in.eq     = (base_s3.op == hva_pkg::OP_CMP) && (&eq_lanes);
		side_in.scalar = dot_s3;
		for (int i = 0; i < L; i++) begin
			side_in.res[i]  = lane_s3[i].res;
			side_in.neg[i]  = lane_s3[i].nsign;
			side_in.nmag[i] = lane_s3[i].nmag;
		end
	end

	// finish magnitude, zero checks and divider operands once the root is out
	always_comb begin
		mid   = line_a_q[DA-1];
		s_abs = mid.s[W-1] ? W'(-mid.s) : mid.s;
		den   = (mid.op == hva_pkg::OP_DIV) ? s_abs : root;
		if (mid.op == hva_pkg::OP_MAG)
			mid.scalar = root[W-1] ? hva_pkg::WORD_MAX : root;
		if ((mid.op == hva_pkg::OP_DIV && mid.s == '0) ||
				(mid.op == hva_pkg::OP_NORM && root == '0))
			mid.inv = 1'b1;
		for (int i = 0; i < L; i++)
			mid.neg[i] = line_a_q[DA-1].neg[i] ^ ((mid.op == hva_pkg::OP_DIV) && mid.s[W-1]);
	end

	for (genvar i = 0; i < L; i++) begin : g_div
		hva_div u_div (
			.clk (clk),
			.en  (en),
			.num (line_a_q[DA-1].nmag[i]),
			.den (den),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			line_a_q[0] <= side_in;
			for (int k = 1; k < DA; k++)
				line_a_q[k] <= line_a_q[k-1];
			line_b_q[0] <= mid;
			for (int k = 1; k < DB; k++)
				line_b_q[k] <= line_b_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			va_q <= '0;
			vb_q <= '0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			va_q <= {va_q[DA-2:0], v_s3};
			vb_q <= {vb_q[DB-2:0], va_q[DA-1]};
		end
	end

	// apply sign and clamp the quotients
	always_comb begin
		fin = line_b_q[DB-1];
		if ((fin.op == hva_pkg::OP_DIV || fin.op == hva_pkg::OP_NORM) && !fin.inv) begin
			for (int i = 0; i < L; i++) begin
				if (fin.neg[i])
					fin.res[i] = (quo[i] > hva_pkg::NUM_W'(unsigned'(hva_pkg::WORD_MIN))) ?
						hva_pkg::WORD_MIN : W'(-quo[i]);
				else
					fin.res[i] = (quo[i] > hva_pkg::NUM_W'(hva_pkg::WORD_MAX)) ?
						hva_pkg::WORD_MAX : quo[i][W-1:0];
			end
		end
	end

	// pack the result word
	always_comb begin
		out_d = '0;
		for (int i = 0; i < L; i++)
			out_d[i*W +: W] = fin.res[i];
		out_d[hva_pkg::SC_LSB +: W] = fin.scalar;
		out_d[hva_pkg::EQ_BIT]      = fin.eq;
		out_d[hva_pkg::APT_BIT]     = fin.apt;
		out_d[hva_pkg::AVEC_BIT]    = fin.avec;
		out_d[hva_pkg::INV_BIT]     = fin.inv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= vb_q[DB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata <= out_d;
	end

`ifndef SYNTHESIS
	a_eq_not_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[hva_pkg::EQ_BIT] && m_tdata[hva_pkg::INV_BIT]))
		else $error("equal and invalid raised together");

	a_tail_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && vb_q[DB-1]) |=> m_tvalid)
		else $error("finished result not moved to output register");

	a_freeze_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && vb_q[DB-1]))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

### tb/sv/tb_homogeneous_vector_alu.sv
// Self-checking testbench for the homogeneous vector ALU: directed and random operations.
`timescale 1ns / 1ps
module tb_homogeneous_vector_alu;

	typedef logic signed [65:0] wide_t;

	typedef struct {
		logic [hva_pkg::OP_W-1:0] op;
		hva_pkg::word_t           a [hva_pkg::LANES];
		hva_pkg::word_t           b [hva_pkg::LANES];
		hva_pkg::word_t           s;
	} vec_op_t;

	typedef struct packed {
		hva_pkg::word_t rx, ry, rz, rw, sc;
		logic           eq, apt, avec, inv;
	} vec_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	// op[3:0], ax, ay, az, aw, bx, by, bz, bw, scale (32 each), zero pad
	logic [hva_pkg::IN_W-1:0]     s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	// rx, ry, rz, rw, scalar_out (32 each), equal, a_is_point, a_is_vector, invalid, zero pad
	logic [hva_pkg::OUT_W-1:0]    m_tdata;
	logic                         epsilon_we = 1'b0;
	logic [hva_pkg::EPS_W-1:0]    epsilon_wdata = '0;

	logic [hva_pkg::EPS_W-1:0]    tol = hva_pkg::EPS_RESET;
	vec_result_t                  pending_results[$];
	int                           errors = 0;
	int                           stall_left = 0;
	bit                           rx_quiet = 1'b0;
	bit                           tx_quiet = 1'b0;

	homogeneous_vector_alu DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.epsilon_we(epsilon_we), .epsilon_wdata(epsilon_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// ---------------- prediction ----------------

	function automatic hva_pkg::word_t clamp_word(input wide_t v);
		if (v > wide_t'(hva_pkg::WORD_MAX))
			return hva_pkg::WORD_MAX;
		if (v < wide_t'(hva_pkg::WORD_MIN))
			return hva_pkg::WORD_MIN;
		return v[hva_pkg::WORD_W-1:0];
	endfunction

	function automatic wide_t mul_exact(input hva_pkg::word_t x, input hva_pkg::word_t y);
		wide_t wx, wy;
		wx = x;
		wy = y;
		return wx * wy;
	endfunction

	// round to nearest Q16.16 step, ties upward
	function automatic hva_pkg::word_t round_q(input wide_t v);
		return clamp_word((v + (wide_t'(1) <<< (hva_pkg::FRAC_BITS - 1))) >>> hva_pkg::FRAC_BITS);
	endfunction

	function automatic hva_pkg::word_t div_q(input hva_pkg::word_t x, input longint d);
		longint num;
		num = longint'(x) * (longint'(1) << hva_pkg::FRAC_BITS);
		return clamp_word(wide_t'(num / d));
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic bit within_tol(input hva_pkg::word_t x, input hva_pkg::word_t y);
		longint d;
		d = longint'(x) - longint'(y);
		if (d < 0)
			d = -d;
		return d < longint'(tol);
	endfunction

	function automatic vec_result_t predict_vec_op(input vec_op_t it);
		vec_result_t     res;
		hva_pkg::word_t  r [hva_pkg::LANES];
		logic [65:0]     sq_sum;
		longint unsigned root;
		bit              bvec;
		res = '0;
		foreach (r[i])
			r[i] = '0;
		res.apt  = within_tol(it.a[3], hva_pkg::ONE);
		res.avec = within_tol(it.a[3], '0);
		bvec     = within_tol(it.b[3], '0);
		case (it.op) inside
			hva_pkg::OP_ADD: begin
				res.inv = !(res.avec || bvec);
				foreach (r[i]) r[i] = clamp_word(wide_t'(it.a[i]) + wide_t'(it.b[i]));
			end
			hva_pkg::OP_SUB: begin
				res.inv = res.avec && !bvec;
				foreach (r[i]) r[i] = clamp_word(wide_t'(it.a[i]) - wide_t'(it.b[i]));
			end
			hva_pkg::OP_NEG:   foreach (r[i]) r[i] = clamp_word(-wide_t'(it.a[i]));
			hva_pkg::OP_SCALE: foreach (r[i]) r[i] = round_q(mul_exact(it.a[i], it.s));
			hva_pkg::OP_DIV: begin
				if (it.s == 0)
					res.inv = 1'b1;
				else
					foreach (r[i]) r[i] = div_q(it.a[i], longint'(it.s));
			end
			hva_pkg::OP_DOT: res.sc = round_q(mul_exact(it.a[0], it.b[0])
				+ mul_exact(it.a[1], it.b[1]) + mul_exact(it.a[2], it.b[2])
				+ mul_exact(it.a[3], it.b[3]));
			hva_pkg::OP_CROSS: begin
				r[0] = round_q(mul_exact(it.a[1], it.b[2]) - mul_exact(it.a[2], it.b[1]));
				r[1] = round_q(mul_exact(it.a[2], it.b[0]) - mul_exact(it.a[0], it.b[2]));
				r[2] = round_q(mul_exact(it.a[0], it.b[1]) - mul_exact(it.a[1], it.b[0]));
			end
			hva_pkg::OP_MAG, hva_pkg::OP_NORM: begin
				sq_sum = '0;
				foreach (it.a[i]) sq_sum = sq_sum + 66'(mul_exact(it.a[i], it.a[i]));
				// hold the sum of squares at the top of 64 bits
				if (sq_sum[65:64] != 0)
					sq_sum = {2'b00, 64'hFFFF_FFFF_FFFF_FFFF};
				root = floor_sqrt(sq_sum[63:0]);
				if (it.op == hva_pkg::OP_MAG)
					res.sc = clamp_word(wide_t'(root));
				else if (root == 0)
					res.inv = 1'b1;
				else
					foreach (r[i]) r[i] = div_q(it.a[i], longint'(root));
			end
			hva_pkg::OP_CMP: begin
				res.eq = 1'b1;
				foreach (it.a[i])
					if (!within_tol(it.a[i], it.b[i]))
						res.eq = 1'b0;
			end
			default: res.inv = 1'b1;
		endcase
		res.rx = r[0];
		res.ry = r[1];
		res.rz = r[2];
		res.rw = r[3];
		return res;
	endfunction

	// ---------------- driving ----------------

	function automatic int gap_len(input bit quiet);
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_vec_op(input vec_op_t it);
		int  gap;
		bit  taken;
		gap = gap_len(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= hva_pkg::IN_W'({it.s, it.b[3], it.b[2], it.b[1], it.b[0],
			it.a[3], it.a[2], it.a[1], it.a[0], it.op});
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(predict_vec_op(it));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [hva_pkg::EPS_W-1:0] v);
		wait_idle();
		epsilon_we    <= 1'b1;
		epsilon_wdata <= v;
		@(posedge clk);
		epsilon_we <= 1'b0;
		tol = v;
		@(posedge clk);
	endtask

	// receiver back-pressure: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 2);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------- checking ----------------

	task automatic report_mismatch(input string field, input longint got, input longint want);
		errors++;
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
	endtask

	always @(negedge clk) begin
		vec_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[0 +: hva_pkg::WORD_W], m_tdata[hva_pkg::WORD_W +: hva_pkg::WORD_W],
				m_tdata[2*hva_pkg::WORD_W +: hva_pkg::WORD_W],
				m_tdata[3*hva_pkg::WORD_W +: hva_pkg::WORD_W],
				m_tdata[hva_pkg::SC_LSB +: hva_pkg::WORD_W], m_tdata[hva_pkg::EQ_BIT],
				m_tdata[hva_pkg::APT_BIT], m_tdata[hva_pkg::AVEC_BIT], m_tdata[hva_pkg::INV_BIT]};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.rx != want.rx) report_mismatch("rx", got.rx, want.rx);
				if (got.ry != want.ry) report_mismatch("ry", got.ry, want.ry);
				if (got.rz != want.rz) report_mismatch("rz", got.rz, want.rz);
				if (got.rw != want.rw) report_mismatch("rw", got.rw, want.rw);
				if (got.sc != want.sc) report_mismatch("scalar_out", got.sc, want.sc);
				if (got.eq != want.eq) report_mismatch("equal", got.eq, want.eq);
				if (got.apt != want.apt) report_mismatch("a_is_point", got.apt, want.apt);
				if (got.avec != want.avec) report_mismatch("a_is_vector", got.avec, want.avec);
				if (got.inv != want.inv) report_mismatch("invalid", got.inv, want.inv);
			end
		end
	end

	// ---------------- stimulus ----------------

	function automatic hva_pkg::word_t rand_word();
		case ($urandom_range(0, 9))
			0:       return hva_pkg::WORD_MAX;
			1:       return hva_pkg::WORD_MIN;
			2:       return '0;
			3, 4:    return hva_pkg::word_t'($urandom_range(0, 20)) * hva_pkg::ONE
				* (($urandom_range(0, 1) != 0) ? -1 : 1);
			5, 6:    return hva_pkg::word_t'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
			default: return hva_pkg::word_t'($urandom());
		endcase
	endfunction

	// w mostly a clean point or vector, sometimes near the tolerance edge
	function automatic hva_pkg::word_t rand_w();
		int off;
		off = $signed($urandom_range(0, 2 * tol + 4)) - (tol + 2);
		case ($urandom_range(0, 7))
			0, 1:    return '0;
			2, 3:    return hva_pkg::ONE;
			4:       return hva_pkg::word_t'(off);
			5:       return hva_pkg::ONE + hva_pkg::word_t'(off);
			default: return rand_word();
		endcase
	endfunction

	function automatic vec_op_t make_vec_op(input logic [hva_pkg::OP_W-1:0] op);
		vec_op_t it;
		it.op = op;
		for (int i = 0; i < hva_pkg::LANES - 1; i++) begin
			it.a[i] = rand_word();
			it.b[i] = rand_word();
		end
		it.a[3] = rand_w();
		it.b[3] = rand_w();
		it.s    = ($urandom_range(0, 9) == 0) ? '0 : rand_word();
		// compare: often let b sit within a small distance of a
		if (op == hva_pkg::OP_CMP && $urandom_range(0, 1) != 0)
			foreach (it.b[i])
				it.b[i] = it.a[i]
					+ hva_pkg::word_t'($signed($urandom_range(0, 2 * tol + 2)) - tol - 1);
		return it;
	endfunction

	function automatic vec_op_t fill_vec_op(input logic [hva_pkg::OP_W-1:0] op,
			input hva_pkg::word_t av, input hva_pkg::word_t aw, input hva_pkg::word_t bv,
			input hva_pkg::word_t bw, input hva_pkg::word_t s);
		vec_op_t it;
		it.op = op;
		it.a  = '{av, av, av, aw};
		it.b  = '{bv, bv, bv, bw};
		it.s  = s;
		return it;
	endfunction

	task automatic test_directed();
		send_vec_op(fill_vec_op(hva_pkg::OP_ADD, hva_pkg::ONE, hva_pkg::ONE, hva_pkg::ONE,
			hva_pkg::ONE, '0));                                           // point + point
		send_vec_op(fill_vec_op(hva_pkg::OP_ADD, hva_pkg::WORD_MAX, '0, hva_pkg::WORD_MAX,
			hva_pkg::ONE, '0));                                           // saturating sum
		send_vec_op(fill_vec_op(hva_pkg::OP_ADD, hva_pkg::WORD_MIN, hva_pkg::ONE,
			hva_pkg::WORD_MIN, '0, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_SUB, hva_pkg::ONE, '0, hva_pkg::ONE,
			hva_pkg::ONE, '0));                                           // vector - point
		send_vec_op(fill_vec_op(hva_pkg::OP_SUB, hva_pkg::WORD_MIN, hva_pkg::ONE,
			hva_pkg::WORD_MAX, hva_pkg::ONE, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_NEG, hva_pkg::WORD_MIN, hva_pkg::WORD_MIN,
			'0, '0, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_SCALE, hva_pkg::WORD_MAX, hva_pkg::ONE, '0, '0,
			hva_pkg::WORD_MAX));
		send_vec_op(fill_vec_op(hva_pkg::OP_SCALE, 32'sh8000, '0, '0, '0, 32'sh1)); // tie
		send_vec_op(fill_vec_op(hva_pkg::OP_SCALE, -32'sh8000, '0, '0, '0, 32'sh1));
		send_vec_op(fill_vec_op(hva_pkg::OP_DIV, hva_pkg::ONE, hva_pkg::ONE, '0, '0,
			'0));                                                         // zero divisor
		send_vec_op(fill_vec_op(hva_pkg::OP_DIV, hva_pkg::WORD_MIN, hva_pkg::ONE, '0, '0,
			32'sh1));
		send_vec_op(fill_vec_op(hva_pkg::OP_DIV, -32'sh7, '0, '0, '0, 32'sh30000));
		send_vec_op(fill_vec_op(hva_pkg::OP_DOT, hva_pkg::WORD_MIN, hva_pkg::WORD_MIN,
			hva_pkg::WORD_MIN, hva_pkg::WORD_MIN, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_DOT, hva_pkg::ONE, '0, -hva_pkg::ONE,
			hva_pkg::ONE, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_CROSS, hva_pkg::WORD_MAX, '0, hva_pkg::WORD_MIN,
			hva_pkg::ONE, '0));
		send_vec_op('{hva_pkg::OP_CROSS, '{hva_pkg::ONE, '0, '0, '0},
			'{'0, hva_pkg::ONE, '0, '0}, '0});
		send_vec_op(fill_vec_op(hva_pkg::OP_MAG, hva_pkg::WORD_MIN, hva_pkg::WORD_MIN,
			'0, '0, '0));                                                 // saturating squares
		send_vec_op(fill_vec_op(hva_pkg::OP_MAG, '0, '0, '0, '0, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_NORM, '0, '0, '0, '0, '0));   // zero length
		send_vec_op(fill_vec_op(hva_pkg::OP_NORM, 32'sh1, '0, '0, '0, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_NORM, 3 * hva_pkg::ONE, hva_pkg::WORD_MIN,
			'0, '0, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_CMP, hva_pkg::ONE, hva_pkg::ONE,
			hva_pkg::ONE + 1, hva_pkg::ONE, '0));
		send_vec_op(fill_vec_op(hva_pkg::OP_CMP, hva_pkg::WORD_MAX, '0, hva_pkg::WORD_MIN,
			'0, '0));
		send_vec_op(fill_vec_op(4'd10, hva_pkg::ONE, hva_pkg::ONE, hva_pkg::ONE,
			hva_pkg::ONE, hva_pkg::ONE));                                 // unknown codes
		send_vec_op(fill_vec_op(4'd15, hva_pkg::WORD_MIN, '0, hva_pkg::WORD_MAX, '0,
			hva_pkg::WORD_MAX));
	endtask

	task automatic test_random(input int count);
		logic [hva_pkg::OP_W-1:0] op;
		for (int n = 0; n < count; n++) begin
			// switch between idle-free stretches and gappy traffic
			if (n % 100 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			op = ($urandom_range(0, 19) == 0) ? hva_pkg::OP_W'($urandom_range(10, 15))
				: hva_pkg::OP_W'($urandom_range(0, 9));
			send_vec_op(make_vec_op(op));
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(350);
		set_tolerance('0);
		test_directed();
		test_random(350);
		set_tolerance(16'hFFFF);
		test_directed();
		test_random(350);
		set_tolerance(16'($urandom_range(1, 300)));
		test_random(350);
		set_tolerance(hva_pkg::EPS_RESET);
		test_random(100);
		wait_idle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
